FILE: rtl/core/cowa_pkg.sv
// Shared types, constants and the reciprocal table for the curvature offset
// window average unit. Depends on nothing; every other file imports it.
`default_nettype none

package cowa_pkg;

    localparam int RADIUS = 3;
    localparam int LAG = (RADIUS < 2) ? 2 : RADIUS;
    localparam int BUF = RADIUS + LAG + 1;
    localparam int WIN = 2 * RADIUS + 1;
    localparam int IDX_W = $clog2(BUF);
    localparam int FILL_W = $clog2(BUF + 1);
    localparam int CMP_W = IDX_W + 2;
    localparam int CNT_W = $clog2(WIN + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W = 27;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [15:0] WIDTH_FRACTION_RST = 16'd11469;
    localparam logic [15:0] CURVATURE_GAIN_RST = 16'd4608;
    localparam logic [22:0] DEAD_BAND_RST = 23'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_FRACTION = 2'd0,
        CFG_CURVATURE_GAIN = 2'd1,
        CFG_DEAD_BAND      = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [23:0] curvature;
        logic [15:0]        width;
        logic               last;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] offset;
        logic               last_out;
    } out_beat_t;

    typedef struct packed {
        logic              shift;
        logic              short_mode;
        logic [IDX_W-1:0]  p;
        logic [FILL_W-1:0] avail;
    } cell_ctrl_t;

    // Ceiling of 2^26 divided by the count; exact truncation for sums below 2^21.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
        logic [4:0] c5;
        logic [RECIP_W-1:0] r;
        c5 = 5'(c);
        case (c5)
            5'd1:    r = 27'd67108864;
            5'd2:    r = 27'd33554432;
            5'd3:    r = 27'd22369622;
            5'd4:    r = 27'd16777216;
            5'd5:    r = 27'd13421773;
            5'd6:    r = 27'd11184811;
            5'd7:    r = 27'd9586981;
            5'd8:    r = 27'd8388608;
            5'd9:    r = 27'd7456541;
            5'd10:   r = 27'd6710887;
            5'd11:   r = 27'd6100806;
            5'd12:   r = 27'd5592406;
            5'd13:   r = 27'd5162221;
            5'd14:   r = 27'd4793491;
            5'd15:   r = 27'd4473925;
            5'd16:   r = 27'd4194304;
            5'd17:   r = 27'd3947581;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cowa_cell.sv
// One window cell: holds one raw offset, passes it to its neighbor on a shift,
// and reports whether it belongs to the averaging window. Uses cowa_pkg.
`default_nettype none

module cowa_cell
    import cowa_pkg::*;
(
    input  wire logic               clk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [IDX_W-1:0]   pos,
    input  wire logic signed [15:0] d,
    output logic signed [15:0]      q,
    output logic signed [15:0]      term,
    output logic                    hit
);

    logic signed [15:0] value_reg;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   p_x;
    logic               present;
    logic               in_range;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= d;
        end
    end

    always_comb
    begin
        pos_x    = CMP_W'(pos);
        p_x      = CMP_W'(ctrl.p);
        present  = pos_x < CMP_W'(ctrl.avail);
        in_range = ((pos_x + CMP_W'(RADIUS)) >= p_x) && (pos_x <= (p_x + CMP_W'(RADIUS)));
        hit      = present && (ctrl.short_mode ? (pos_x == p_x) : in_range);
        term     = hit ? value_reg : 16'sd0;
    end

    assign q = value_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cowa_raw.sv
// Raw offset unit: registered width and curvature products, then minimum,
// saturation, sign and dead band. Uses cowa_pkg.
`default_nettype none

module cowa_raw
    import cowa_pkg::*;
(
    input  wire logic        clk,
    input  wire in_beat_t    beat,
    input  wire logic [15:0] width_fraction,
    input  wire logic [15:0] curvature_gain,
    input  wire logic [22:0] dead_band,
    output logic signed [15:0] raw
);

    logic [23:0] mag;
    logic [31:0] wprod_reg;
    logic [39:0] kprod_reg;
    logic        neg_reg;
    logic        dead_reg;
    logic [19:0] a_val;
    logic [19:0] b_val;
    logic [19:0] m_val;
    logic [14:0] sat;

    assign mag = beat.curvature[23] ? (~beat.curvature + 24'd1) : beat.curvature;

    always_ff @(posedge clk)
    begin
        wprod_reg <= beat.width * width_fraction;
        kprod_reg <= mag * curvature_gain;
        neg_reg   <= beat.curvature[23];
        dead_reg  <= mag <= {1'b0, dead_band};
    end

    always_comb
    begin
        a_val = {4'd0, wprod_reg[31:16]};
        b_val = kprod_reg[39:20];
        m_val = (a_val < b_val) ? a_val : b_val;
        sat   = (m_val > 20'd32767) ? 15'h7fff : m_val[14:0];
        if (dead_reg)
        begin
            raw = 16'sd0;
        end
        else if (neg_reg)
        begin
            raw = -$signed({1'b0, sat});
        end
        else
        begin
            raw = $signed({1'b0, sat});
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cowa_div.sv
// Window average divider: magnitude times a tabled reciprocal, registered,
// then sign restored so the quotient truncates toward zero. Uses cowa_pkg.
`default_nettype none

module cowa_div
    import cowa_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [SUM_W-1:0] sum,
    input  wire logic [CNT_W-1:0]        cnt,
    output logic signed [15:0]           quot
);

    logic [SUM_W-1:0]             neg_sum;
    logic [SUM_W-2:0]             mag;
    logic [SUM_W-2+RECIP_W:0]     prod_reg;
    logic                         neg_reg;
    logic [14:0]                  q_mag;

    assign neg_sum = -sum;
    assign mag     = sum[SUM_W-1] ? neg_sum[SUM_W-2:0] : sum[SUM_W-2:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= mag * recip(cnt);
        neg_reg  <= sum[SUM_W-1];
    end

    assign q_mag = prod_reg[RECIP_SHIFT+14:RECIP_SHIFT];
    assign quot  = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

endmodule

`default_nettype wire

FILE: rtl/core/curvature_offset_window_average_unit.sv
// Top level of the curvature offset window average unit: handshakes, config
// registers, sequencer, the row of window cells and the window sum.
// Uses cowa_pkg, cowa_raw, cowa_cell and cowa_div.
//
//   port group | direction | handshake            | payload
//   in         | inbound   | in_valid / in_stall  | in_beat (curvature, width, last)
//   out        | outbound  | out_valid / out_stall| out_beat (offset, last_out)
//   cfg        | inbound   | cfg_we               | cfg_index, cfg_data
//
// A sample passes the input and product registers before it is shifted into
// the window; each result then sums the cells, does the reciprocal multiply and
// loads the output register. A plain sample causes no result or one, a closing
// one up to LAG + 1. The reset is asynchronous and clears the control
// state and the configuration registers; the window cells are not reset.
// A stalled output holds the sequencer in its emit step.
`default_nettype none

module curvature_offset_window_average_unit
    import cowa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_beat_t              in_beat,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_beat_t                  out_beat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SHIFT = 6'b000100,
        S_SUM   = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                  state_reg;
    in_beat_t                in_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic [IDX_W-1:0]        p_reg;
    logic [IDX_W-1:0]        top_p;
    logic                    flush_reg;
    logic                    short_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0]        cnt_acc;
    logic                    out_valid_reg;
    out_beat_t               out_reg;
    logic                    out_free;
    logic [15:0]             width_fraction_reg;
    logic [15:0]             curvature_gain_reg;
    logic [22:0]             dead_band_reg;
    logic signed [15:0]      raw;
    logic signed [15:0]      quot;
    cell_ctrl_t              ctrl;
    logic signed [15:0]      cell_q    [BUF];
    logic signed [15:0]      cell_term [BUF];
    logic [BUF-1:0]          cell_hit;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_fraction_reg <= WIDTH_FRACTION_RST;
            curvature_gain_reg <= CURVATURE_GAIN_RST;
            dead_band_reg      <= DEAD_BAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH_FRACTION: width_fraction_reg <= cfg_data[15:0];
                CFG_CURVATURE_GAIN: curvature_gain_reg <= cfg_data[15:0];
                CFG_DEAD_BAND:      dead_band_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    cowa_raw u_raw (
        .clk            (clk),
        .beat           (in_reg),
        .width_fraction (width_fraction_reg),
        .curvature_gain (curvature_gain_reg),
        .dead_band      (dead_band_reg),
        .raw            (raw)
    );

    always_comb
    begin
        ctrl.shift      = (state_reg == S_SHIFT);
        ctrl.short_mode = short_reg;
        ctrl.p          = p_reg;
        ctrl.avail      = fill_reg;
    end

    for (genvar i = 0; i < BUF; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            cowa_cell u_cell (
                .clk  (clk),
                .ctrl (ctrl),
                .pos  (IDX_W'(i)),
                .d    (raw),
                .q    (cell_q[i]),
                .term (cell_term[i]),
                .hit  (cell_hit[i])
            );
        end
        else
        begin : g_body
            cowa_cell u_cell (
                .clk  (clk),
                .ctrl (ctrl),
                .pos  (IDX_W'(i)),
                .d    (cell_q[i-1]),
                .q    (cell_q[i]),
                .term (cell_term[i]),
                .hit  (cell_hit[i])
            );
        end
    end

    always_comb
    begin
        sum_acc = '0;
        cnt_acc = '0;
        for (int i = 0; i < BUF; i++)
        begin
            sum_acc = sum_acc + SUM_W'(cell_term[i]);
            cnt_acc = cnt_acc + CNT_W'(cell_hit[i]);
        end
    end

    cowa_div u_div (
        .clk  (clk),
        .sum  (sum_reg),
        .cnt  (cnt_reg),
        .quot (quot)
    );

    always_comb
    begin
        fill_next = (fill_reg < FILL_W'(BUF)) ? fill_reg + FILL_W'(1) : fill_reg;
        top_p     = ((fill_next - FILL_W'(1)) < FILL_W'(LAG)) ?
                    IDX_W'(fill_next - FILL_W'(1)) : IDX_W'(LAG);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            in_reg <= in_beat;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_acc;
            cnt_reg <= cnt_acc;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_reg.offset   <= quot;
            out_reg.last_out <= flush_reg && (p_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            p_reg         <= '0;
            flush_reg     <= 1'b0;
            short_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    fill_reg <= fill_next;
                    if (in_reg.last)
                    begin
                        flush_reg <= 1'b1;
                        short_reg <= fill_next < FILL_W'(3);
                        p_reg     <= top_p;
                        state_reg <= S_SUM;
                    end
                    else if (fill_next >= FILL_W'(LAG + 1))
                    begin
                        flush_reg <= 1'b0;
                        short_reg <= 1'b0;
                        p_reg     <= IDX_W'(LAG);
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SUM:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (flush_reg && p_reg != '0)
                        begin
                            p_reg     <= p_reg - IDX_W'(1);
                            state_reg <= S_SUM;
                        end
                        else
                        begin
                            if (flush_reg)
                            begin
                                fill_reg  <= '0;
                                flush_reg <= 1'b0;
                                short_reg <= 1'b0;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cowa_checker.sv
// Port-level checks for the curvature offset window average unit and the bind
// that attaches them to the top level. Uses cowa_pkg.
`default_nettype none

module cowa_checker
    import cowa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_stall,
    input  wire logic      out_valid,
    input  wire logic      out_stall,
    input  wire out_beat_t out_beat
);

    // A stalled result beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_beat))
        else $error("stalled output beat changed");

    // The unit works on one sample at a time, so an accepted beat closes the input.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a sample is in progress");

    // A new result only appears while the unit is busy with a sample.
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no sample in progress");

    // Averages of saturated offsets never reach the most negative code.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_beat.offset != 16'sh8000)
        else $error("offset outside the saturated range");

endmodule

bind curvature_offset_window_average_unit cowa_checker u_cowa_checker (.*);

`default_nettype wire
